>>> rtl/drl_pkg.sv
// Package for the decimated RMS level unit: widths, limits and the job record
// handed from the accumulating front end to the divide/square-root back end.
// No dependencies.
`default_nettype none

package drl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STEP_BITS   = 7;
  localparam int PHASE_BITS  = 6;
  localparam int MAX_STEP    = 64;
  localparam int MAX_FRAMES  = 65536;
  localparam int CNT_BITS    = 17;
  localparam int SQ_BITS     = 31;   // (2^15)^2 = 2^30 needs 31 bits
  localparam int SUM_BITS    = 47;   // MAX_FRAMES * 2^30
  localparam int MEAN_BITS   = 31;   // mean of squares never exceeds 2^30
  localparam int ROOT_W      = 32;   // work width of the square-root loop
  localparam int ROOT_STEPS  = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] cnt;
  } drl_job_t;

endpackage

`default_nettype wire

>>> rtl/drl_ifs.sv
// Valid/ready channel interfaces for the decimated RMS level unit.
// Depends on drl_pkg for field widths.
`default_nettype none

interface drl_sample_if;
  logic                             valid;
  logic                             ready;
  logic [drl_pkg::SAMPLE_BITS-1:0]  sample;
  logic                             last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface drl_level_if;
  logic                             valid;
  logic                             ready;
  logic [drl_pkg::SAMPLE_BITS-1:0]  rms_amplitude;

  modport source (output valid, output rms_amplitude, input ready);
  modport sink   (input valid, input rms_amplitude, output ready);
endinterface

`default_nettype wire

>>> rtl/drl_front.sv
// Front end: takes samples, applies decimation, squares and accumulates,
// and pushes one job per buffer. Depends on drl_pkg and drl_sample_if.
`default_nettype none

module drl_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  drl_sample_if.sink                           in_ch,
  input  wire logic [drl_pkg::STEP_BITS-1:0]   step_i,
  input  wire logic                            pop_i,
  output      logic                            push_o,
  output      drl_pkg::drl_job_t               job_o
);

  logic [drl_pkg::PHASE_BITS-1:0]  phase_q;
  logic [drl_pkg::CNT_BITS-1:0]    cnt_q;
  logic [drl_pkg::QCNT_BITS-1:0]   credit_q, credit_d;
  logic [drl_pkg::SUM_BITS-1:0]    sum_q, sum_next;

  logic [drl_pkg::STEP_BITS-1:0]   step_eff, ph_inc;
  logic [drl_pkg::PHASE_BITS-1:0]  ph, phase_d;
  logic [drl_pkg::SAMPLE_BITS-1:0] mag;
  logic                            take, acc;
  logic [drl_pkg::CNT_BITS-1:0]    cnt_new;

  // stage 1: magnitude and take flag
  logic                            v1_q, take1_q, last1_q;
  logic [drl_pkg::SAMPLE_BITS-1:0] mag1_q;
  logic [drl_pkg::CNT_BITS-1:0]    cnt1_q;
  // stage 2: square
  logic                            v2_q, last2_q;
  logic [drl_pkg::SQ_BITS-1:0]     sq2_q;
  logic [drl_pkg::CNT_BITS-1:0]    cnt2_q;
  logic [2*drl_pkg::SAMPLE_BITS-1:0] prod;

  // one credit per queue slot, reserved when a last beat is taken
  assign in_ch.ready = (credit_q < drl_pkg::QCNT_BITS'(drl_pkg::QDEPTH));
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    if (step_i == '0) begin
      step_eff = drl_pkg::STEP_BITS'(1);
    end else if (step_i > drl_pkg::STEP_BITS'(drl_pkg::MAX_STEP)) begin
      step_eff = drl_pkg::STEP_BITS'(drl_pkg::MAX_STEP);
    end else begin
      step_eff = step_i;
    end
    ph      = ({1'b0, phase_q} >= step_eff) ? '0 : phase_q;
    take    = (ph == '0) && (cnt_q < drl_pkg::CNT_BITS'(drl_pkg::MAX_FRAMES));
    ph_inc  = {1'b0, ph} + drl_pkg::STEP_BITS'(1);
    phase_d = (ph_inc >= step_eff) ? '0 : ph_inc[drl_pkg::PHASE_BITS-1:0];
    cnt_new = cnt_q + drl_pkg::CNT_BITS'(take);
    // full-scale negative maps to 32768, which fits unsigned 16 bits
    mag     = in_ch.sample[drl_pkg::SAMPLE_BITS-1]
            ? (~in_ch.sample + drl_pkg::SAMPLE_BITS'(1)) : in_ch.sample;
    prod    = mag1_q * mag1_q;
    sum_next = sum_q + drl_pkg::SUM_BITS'(sq2_q);
    credit_d = credit_q + drl_pkg::QCNT_BITS'(acc && in_ch.last)
             - drl_pkg::QCNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      credit_q <= '0;
      sum_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      credit_q <= credit_d;
      v1_q     <= acc;
      v2_q     <= v1_q;
      if (acc) begin
        phase_q <= in_ch.last ? '0 : phase_d;
        cnt_q   <= in_ch.last ? '0 : cnt_new;
      end
      if (v2_q) begin
        sum_q <= last2_q ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    take1_q <= take;
    last1_q <= in_ch.last;
    mag1_q  <= mag;
    cnt1_q  <= cnt_new;
    last2_q <= last1_q;
    cnt2_q  <= cnt1_q;
    sq2_q   <= take1_q ? prod[drl_pkg::SQ_BITS-1:0] : '0;
  end

  assign push_o    = v2_q && last2_q;
  assign job_o.sum = sum_next;
  assign job_o.cnt = cnt2_q;

endmodule

`default_nettype wire

>>> rtl/drl_queue.sv
// Short job queue between front and back end.
// Depends on drl_pkg. Overflow is prevented by the front end's credits.
`default_nettype none

module drl_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire drl_pkg::drl_job_t   job_i,
  input  wire logic                pop_i,
  output      logic                valid_o,
  output      drl_pkg::drl_job_t   job_o
);

  drl_pkg::drl_job_t               mem_q [drl_pkg::QDEPTH];
  logic [drl_pkg::QPTR_BITS-1:0]   wr_q, rd_q;
  logic [drl_pkg::QCNT_BITS-1:0]   cnt_q;

  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + drl_pkg::QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + drl_pkg::QPTR_BITS'(1);
      end
      cnt_q <= cnt_q + drl_pkg::QCNT_BITS'(push_i) - drl_pkg::QCNT_BITS'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/drl_back.sv
// Back end: bit-serial division of the sum by the count, then a
// digit-by-digit integer square root. Depends on drl_pkg and drl_level_if.
`default_nettype none

module drl_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire drl_pkg::drl_job_t   job_i,
  output      logic                pop_o,
  drl_level_if.source              out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } state_e;

  state_e                          state_q;
  logic [drl_pkg::SUM_BITS-1:0]    dvd_q, dvd_d;
  logic [drl_pkg::CNT_BITS-1:0]    div_q;
  logic [drl_pkg::CNT_BITS-1:0]    rem_q, rem_d;
  logic [drl_pkg::CNT_BITS:0]      rem_sh;
  logic [5:0]                      it_q;
  logic [drl_pkg::ROOT_W-1:0]      v_q, root_q, bit_q, v_d, root_d, trial;
  logic [drl_pkg::SAMPLE_BITS-1:0] res_q, rms_q;
  logic                            ovalid_q;

  assign pop_o                = (state_q == ST_IDLE) && q_valid_i;
  assign out_ch.valid         = ovalid_q;
  assign out_ch.rms_amplitude = rms_q;

  always_comb begin
    // restoring division step: one quotient bit per cycle
    rem_sh = {rem_q, dvd_q[drl_pkg::SUM_BITS-1]};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_d = drl_pkg::CNT_BITS'(rem_sh - {1'b0, div_q});
      dvd_d = {dvd_q[drl_pkg::SUM_BITS-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[drl_pkg::CNT_BITS-1:0];
      dvd_d = {dvd_q[drl_pkg::SUM_BITS-2:0], 1'b0};
    end
    // square-root step: one result bit per cycle
    trial = root_q + bit_q;
    if (v_q >= trial) begin
      v_d    = v_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end else begin
      v_d    = v_q;
      root_d = root_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      dvd_q    <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      it_q     <= '0;
      v_q      <= '0;
      root_q   <= '0;
      bit_q    <= '0;
      res_q    <= '0;
      rms_q    <= '0;
    end else begin
      // ST_OUT always leaves a beat on out_ch; otherwise hold until taken
      ovalid_q <= (state_q == ST_OUT) || (ovalid_q && !out_ch.ready);
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            dvd_q   <= job_i.sum;
            div_q   <= job_i.cnt;
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          if (it_q == 6'(drl_pkg::SUM_BITS - 1)) begin
            v_q     <= (div_q == '0) ? '0
                     : drl_pkg::ROOT_W'(dvd_d[drl_pkg::MEAN_BITS-1:0]);
            root_q  <= '0;
            bit_q   <= drl_pkg::ROOT_W'(1) << (2 * (drl_pkg::ROOT_STEPS - 1));
            it_q    <= '0;
            state_q <= ST_ROOT;
          end else begin
            it_q <= it_q + 6'd1;
          end
        end
        ST_ROOT: begin
          v_q    <= v_d;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          it_q   <= it_q + 6'd1;
          if (it_q == 6'(drl_pkg::ROOT_STEPS - 1)) begin
            res_q   <= root_d[drl_pkg::SAMPLE_BITS-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ovalid_q || out_ch.ready) begin
            rms_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/decimated_rms_level_unit.sv
// Decimated RMS level meter, top level.
// Uses drl_pkg, drl_ifs, drl_front, drl_queue and drl_back.
//
// Usage:
//   in_ch  : one signed Q1.15 sample per beat, last marks the end of a buffer.
//   out_ch : one unsigned Q1.15 RMS amplitude per buffer.
//   cfg_we_i/cfg_data_i : decimation step, write only while idle.
// The first sample of a buffer and every Nth one after it are squared and
// summed (at most 65536 per buffer); on the last beat the mean square is
// divided out and its floor square root is sent.
// Throughput: one sample beat per cycle while the job queue has room. Each buffer
// then occupies the back end through its load, bit-serial divide, square-root and
// output steps, and the back end takes the next job only once it is back in idle.
// Up to four finished buffers queue up between front and back end, so short
// buffers stall in_ch only when that queue is full.
// Reset clears all sums, counts and the queue and sets the step to 1.
// If out_ch stalls, the result is held and the back end waits; samples keep
// flowing until the queue fills.
`default_nettype none

module decimated_rms_level_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  drl_sample_if.sink                         in_ch,
  drl_level_if.source                        out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [drl_pkg::STEP_BITS-1:0] cfg_data_i
);

  logic [drl_pkg::STEP_BITS-1:0] step_q;
  logic                          push, pop, q_valid;
  drl_pkg::drl_job_t             push_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= drl_pkg::STEP_BITS'(1);
    end else if (cfg_we_i) begin
      step_q <= cfg_data_i;
    end
  end

  drl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .step_i (step_q),
    .pop_i  (pop),
    .push_o (push),
    .job_o  (push_job)
  );

  drl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  drl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (q_job),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for decimated_rms_level_unit: drives sample beats and step writes,
// predicts each buffer's RMS level and compares every level beat against it.
// Depends on drl_pkg, drl_ifs and the unit's RTL.

class rms_level_tracker;
  logic [drl_pkg::STEP_BITS-1:0]   step;
  logic [drl_pkg::SUM_BITS-1:0]    square_sum;
  logic [drl_pkg::CNT_BITS-1:0]    taken;
  int unsigned                     phase;
  logic [drl_pkg::SAMPLE_BITS-1:0] levels_due[$];
  int                              errors;

  function new();
    step       = 1;
    square_sum = '0;
    taken      = '0;
    phase      = 0;
    errors     = 0;
  endfunction

  function void write_step(logic [drl_pkg::STEP_BITS-1:0] value);
    step = value;
  endfunction

  function logic [drl_pkg::SAMPLE_BITS-1:0] floor_sqrt(longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = drl_pkg::SAMPLE_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root[drl_pkg::SAMPLE_BITS-1:0];
  endfunction

  function void note_sample(logic [drl_pkg::SAMPLE_BITS-1:0] sample, logic last);
    longint          value;
    longint unsigned mag;
    longint unsigned mean;
    int unsigned     n;
    value = longint'($signed(sample));
    mag   = (value < 0) ? -value : value;
    // step 0 acts as 1, anything past the max saturates
    if (step == 0) n = 1;
    else if (step > drl_pkg::MAX_STEP) n = drl_pkg::MAX_STEP;
    else n = step;
    if (phase >= n) phase = 0;
    if (phase == 0 && taken < drl_pkg::MAX_FRAMES) begin
      square_sum += mag * mag;
      taken++;
    end
    phase++;
    if (phase >= n) phase = 0;
    if (last) begin
      mean = (taken != 0) ? square_sum / taken : 0;
      levels_due.push_back(floor_sqrt(mean));
      square_sum = '0;
      taken      = '0;
      phase      = 0;
    end
  endfunction

  function void check_level(logic [drl_pkg::SAMPLE_BITS-1:0] got);
    logic [drl_pkg::SAMPLE_BITS-1:0] want;
    if (levels_due.size() == 0) begin
      $error("rms_amplitude: expected no beat, got %0d", got);
      errors++;
    end else begin
      want = levels_due.pop_front();
      if (got !== want) begin
        $error("rms_amplitude: expected %0d, got %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_top;

  localparam int SW          = drl_pkg::SAMPLE_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 156;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [drl_pkg::STEP_BITS-1:0] cfg_data_i;

  drl_sample_if in_ch();
  drl_level_if  out_ch();

  decimated_rms_level_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  rms_level_tracker tracker = new();

  int src_idle_pct  = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int cycle_count   = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // beat monitor: both sides sampled with pre-edge values
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) tracker.note_sample(in_ch.sample, in_ch.last);
    if (out_ch.valid && out_ch.ready) tracker.check_level(out_ch.rms_amplitude);
  end

  // level sink: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic [SW-1:0] sample, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= sample;
    in_ch.last   <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_buffer(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(pick_sample(), i == len - 1);
  endtask

  task automatic run_random_phase(int unsigned quota);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(16, 1);
      send_buffer(len);
      sent += len;
    end
  endtask

  // stop the input, wait for every pending level, then let the back end go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.levels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(logic [drl_pkg::STEP_BITS-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_step(value);
  endtask

  initial begin
    logic [drl_pkg::STEP_BITS-1:0] next_step;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample buffers at the extremes, then one four-sample buffer
    send_beat(16'h7FFF, 1'b1);
    send_beat(16'h8000, 1'b1);
    send_beat(16'h0000, 1'b1);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h5555, 1'b0);
    send_beat(16'hAAAA, 1'b1);
    settle();
    write_step(64);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h1234, 1'b1);
    settle();
    write_step(0);
    send_beat(16'h4000, 1'b0);
    send_beat(16'hC000, 1'b0);
    send_beat(16'h0100, 1'b1);
    settle();
    write_step(127);
    send_beat(16'h2000, 1'b0);
    send_beat(16'h7FFF, 1'b1);
    settle();
    // step shrinks mid-buffer below the current phase
    write_step(5);
    send_beat(16'h1000, 1'b0);
    send_beat(16'h7000, 1'b0);
    send_beat(16'h9000, 1'b0);
    settle();
    write_step(2);
    send_beat(16'hF000, 1'b0);
    send_beat(16'h0800, 1'b1);
    settle();
    write_step(65);
    send_beat(16'h3000, 1'b0);
    send_beat(16'h8000, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  stall_pct = 0;  end
        1: begin src_idle_pct = 48; stall_pct = 0;  end
        2: begin src_idle_pct = 0;  stall_pct = 48; end
        default: begin src_idle_pct = 31; stall_pct = 31; end
      endcase
      case (p)
        0: next_step = 1;
        1: next_step = 64;
        2: next_step = 0;
        3: next_step = 127;
        4: next_step = 7;
        5: next_step = 7'($urandom_range(64, 1));
        6: next_step = 3;
        default: next_step = 7'($urandom_range(127));
      endcase
      write_step(next_step);
      // receiver goes quiet while samples keep coming, so the job queue fills
      if (p == 1) hold_requests++;
      run_random_phase(PHASE_ITEMS);
      settle();
    end

    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/drl_pkg.sv
rtl/drl_ifs.sv
rtl/drl_front.sv
rtl/drl_queue.sv
rtl/drl_back.sv
rtl/decimated_rms_level_unit.sv
verif/tb_top.sv
